[hw/rtl/cbf_pkg.sv]
// ----------------------------------------------------------------------------
// cbf_pkg
// Shared types and constants of the counting membership filter.
// ----------------------------------------------------------------------------
package cbf_pkg;

	// Number of counters; a power of two, so the slot is the low hash bits.
	localparam int unsigned COUNTER_COUNT = 65536;
	localparam int unsigned SLOT_W        = $clog2(COUNTER_COUNT);
	localparam int unsigned CNT_W         = 8;
	localparam int unsigned HASH_W        = 32;
	localparam int unsigned KIND_W        = 2;

	localparam logic [CNT_W-1:0]  CNT_ZERO = '0;
	localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(COUNTER_COUNT - 1);

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_QUERY  = 2'd0,
		KIND_MARK   = 2'd1,
		KIND_UNMARK = 2'd2
	} cbf_kind_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_A,
		ST_B
	} cbf_state_t;

	// Counter store access issued by the engine.
	typedef struct packed {
		logic  rd_en;
		slot_t rd_addr;
		logic  wr_en;
		slot_t wr_addr;
		cnt_t  wr_data;
	} cbf_mem_req_t;

	// Finished result handed to the output register.
	typedef struct packed {
		logic valid;
		logic maybe_present;
		logic underflow;
	} cbf_res_t;

endpackage

[hw/rtl/cbf_ram.sv]
// ----------------------------------------------------------------------------
// cbf_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// Read during a write to the same address returns the old contents.
// ----------------------------------------------------------------------------
module cbf_ram #(
	parameter int unsigned ADDR_W = 16,
	parameter int unsigned DATA_W = 8
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hw/rtl/cbf_engine.sv]
// ----------------------------------------------------------------------------
// cbf_engine
// Clearing pass and read-modify-write sequencer for the counter store.
// Per item, the first slot is updated while the second is read.
// ----------------------------------------------------------------------------
module cbf_engine
	import cbf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic [KIND_W-1:0]   kind,
	input  logic [HASH_W-1:0]   first_hash,
	input  logic [HASH_W-1:0]   second_hash,
	input  logic                out_can_load,
	output cbf_res_t            res,
	output cbf_mem_req_t        mem_req,
	input  cnt_t                mem_rd_data
);

	cbf_state_t state_q, state_d;
	slot_t      clr_q;
	cbf_kind_t  kind_s1;
	slot_t      slot_a_s1, slot_b_s1;
	logic       nz_a_q, under_a_q;
	logic       byp_valid_q;
	slot_t      byp_addr_q;
	cnt_t       byp_data_q;

	slot_t      cur_addr;
	cnt_t       cur_cnt, new_cnt;
	logic       is_update, shared, accept;

	// Read data is registered; a write issued alongside that read request
	// is not in it, so forward it.
	always_comb begin
		cur_addr = (state_q == ST_A) ? slot_a_s1 : slot_b_s1;
		cur_cnt  = (byp_valid_q && byp_addr_q == cur_addr) ? byp_data_q : mem_rd_data;
		shared   = (slot_a_s1 == slot_b_s1);
		new_cnt  = cur_cnt;
		case (kind_s1)
			KIND_MARK: begin
				if (cur_cnt != CNT_MAX) new_cnt = cur_cnt + CNT_W'(1);
			end
			KIND_UNMARK: begin
				// top value is sticky, zero stays put
				if (cur_cnt != CNT_MAX && cur_cnt != CNT_ZERO) new_cnt = cur_cnt - CNT_W'(1);
			end
			default: new_cnt = cur_cnt;
		endcase
		is_update = (kind_s1 == KIND_MARK) || (kind_s1 == KIND_UNMARK);
	end

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		res        = '0;
		mem_req    = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = clr_q;
				mem_req.wr_data = CNT_ZERO;
				if (clr_q == SLOT_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = first_hash[SLOT_W-1:0];
					state_d         = ST_A;
				end
			end
			ST_A: begin
				mem_req.wr_en   = is_update;
				mem_req.wr_addr = slot_a_s1;
				mem_req.wr_data = new_cnt;
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = slot_b_s1;
				state_d         = ST_B;
			end
			ST_B: begin
				// hold here until the output register can take the result
				if (out_can_load) begin
					mem_req.wr_en     = is_update && !shared;
					mem_req.wr_addr   = slot_b_s1;
					mem_req.wr_data   = new_cnt;
					res.valid         = 1'b1;
					res.maybe_present = (kind_s1 == KIND_QUERY) && nz_a_q &&
					                    (shared || cur_cnt != CNT_ZERO);
					res.underflow     = (kind_s1 == KIND_UNMARK) &&
					                    (under_a_q || (!shared && cur_cnt == CNT_ZERO));
					item_ready        = 1'b1;
					if (item_valid) begin
						mem_req.rd_en   = 1'b1;
						mem_req.rd_addr = first_hash[SLOT_W-1:0];
						state_d         = ST_A;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	assign accept = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			byp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + SLOT_W'(1);
			if (mem_req.rd_en) byp_valid_q <= mem_req.wr_en;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= cbf_kind_t'(kind);
			slot_a_s1 <= first_hash[SLOT_W-1:0];
			slot_b_s1 <= second_hash[SLOT_W-1:0];
		end
		if (state_q == ST_A) begin
			nz_a_q    <= (cur_cnt != CNT_ZERO);
			under_a_q <= (cur_cnt == CNT_ZERO);
		end
		if (mem_req.rd_en) begin
			byp_addr_q <= mem_req.wr_addr;
			byp_data_q <= mem_req.wr_data;
		end
	end

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !item_ready)
		else $error("item taken during clearing pass");

	a_result_only_in_b: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> state_q == ST_B)
		else $error("result produced outside second phase");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !mem_req.wr_en)
		else $error("counter write while idle");

	a_accept_goes_a: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_A)
		else $error("accepted transaction did not start first phase");

	a_second_read_in_a: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_A |-> mem_req.rd_en && mem_req.rd_addr == slot_b_s1)
		else $error("second slot not read in first phase");

endmodule

[hw/rtl/counting_bloom_filter_core.sv]
// ----------------------------------------------------------------------------
// counting_bloom_filter_core
// Counting membership filter over 8-bit counters with two hashed slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel item_valid/item_ready carries kind, first_hash and
//   second_hash; the slot is the low bits of each hash. kind 0 queries,
//   1 increments both slots (saturating at 255), 2 decrements them (255 is
//   sticky, zero stays zero and sets underflow). A shared slot is touched once.
//   Output channel result_valid/result_ready returns one transaction per item:
//   maybe_present and underflow.
//   Each item runs on the single counter RAM in a first and a second phase:
//   the first slot is written back while the second slot is read; a one-entry
//   bypass covers a read issued alongside a write. A new item can be taken in
//   the second phase that hands the previous result to the output register.
//   After reset a clearing pass zeroes all 65536 counters, one per cycle;
//   item_ready stays low until the pass is done.
//   A result waits in the output register while result_ready is low; one more
//   item is taken meanwhile and then holds in its second phase until the
//   output register frees up.
// ----------------------------------------------------------------------------
module counting_bloom_filter_core
	import cbf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [KIND_W-1:0] kind,
	input  logic [HASH_W-1:0] first_hash,
	input  logic [HASH_W-1:0] second_hash,
	output logic              result_valid,
	input  logic              result_ready,
	output logic              maybe_present,
	output logic              underflow
);

	cbf_res_t     res;
	cbf_mem_req_t mem_req;
	cnt_t         mem_rd_data;
	logic         out_valid_q, present_q, under_q;
	logic         out_can_load;

	assign out_can_load = !out_valid_q || result_ready;

	cbf_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.kind         (kind),
		.first_hash   (first_hash),
		.second_hash  (second_hash),
		.out_can_load (out_can_load),
		.res          (res),
		.mem_req      (mem_req),
		.mem_rd_data  (mem_rd_data)
	);

	cbf_ram #(
		.ADDR_W (SLOT_W),
		.DATA_W (CNT_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (mem_req.rd_en),
		.rd_addr (mem_req.rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_req.wr_en),
		.wr_addr (mem_req.wr_addr),
		.wr_data (mem_req.wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			present_q <= res.maybe_present;
			under_q   <= res.underflow;
		end
	end

	assign result_valid  = out_valid_q;
	assign maybe_present = present_q;
	assign underflow     = under_q;

endmodule

[tb/sv/counting_bloom_filter_core_test.sv]
// ----------------------------------------------------------------------------
// counting_bloom_filter_core_test
// Drives query, mark and unmark transactions into the counting filter,
// mirrors the counter store in a scoreboard and checks every result in order.
// Traffic runs under several sender/receiver throttle mixes and includes a long
// receiver stall that backs the block up.
// ----------------------------------------------------------------------------
module counting_bloom_filter_core_test
	import cbf_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
	localparam int WATCHDOG_CYCLES = 200000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int STALL_CYCLES    = 400;
	localparam int REPORT_LIMIT    = 10;
	localparam int FILL_RUN        = 140;
	localparam slot_t HOT_A = slot_t'(16'h00ff);
	localparam slot_t HOT_B = slot_t'(16'h7f00);

	typedef struct packed {
		logic maybe_present;
		logic underflow;
	} verdict_t;

	// Mirror of the counter store plus the queue of outcomes still owed.
	class membership_tracker;
		bit [CNT_W-1:0] slot_counts [COUNTER_COUNT];
		verdict_t verdict_q [$];
		int mismatches;

		function void raise(slot_t s);
			if (slot_counts[s] != CNT_MAX) slot_counts[s]++;
		endfunction

		// Returns 1 when the counter was already empty.
		function bit lower(slot_t s);
			if (slot_counts[s] == CNT_MAX) return 1'b0;
			if (slot_counts[s] == CNT_ZERO) return 1'b1;
			slot_counts[s]--;
			return 1'b0;
		endfunction

		function void note_item(logic [KIND_W-1:0] k, logic [HASH_W-1:0] h1,
				logic [HASH_W-1:0] h2);
			slot_t a;
			slot_t b;
			verdict_t v;
			a = slot_t'(h1 % COUNTER_COUNT);
			b = slot_t'(h2 % COUNTER_COUNT);
			v = '0;
			case (k)
				KIND_QUERY: begin
					v.maybe_present = (slot_counts[a] != CNT_ZERO) &&
						(slot_counts[b] != CNT_ZERO);
				end
				KIND_MARK: begin
					raise(a);
					if (b != a) raise(b);
				end
				KIND_UNMARK: begin
					v.underflow = lower(a);
					if (b != a) begin
						if (lower(b)) v.underflow = 1'b1;
					end
				end
				default: ;
			endcase
			verdict_q.push_back(v);
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
		endfunction

		function void check_result(logic mp, logic uf);
			verdict_t v;
			if (verdict_q.size() == 0) begin
				report($sformatf("result transaction with none pending (mp %b uf %b)",
					mp, uf));
				return;
			end
			v = verdict_q.pop_front();
			if (mp !== v.maybe_present)
				report($sformatf("maybe_present expected %b got %b", v.maybe_present, mp));
			if (uf !== v.underflow)
				report($sformatf("underflow expected %b got %b", v.underflow, uf));
		endfunction

		function int pending();
			return verdict_q.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n       = 1'b0;
	logic              item_valid   = 1'b0;
	logic              item_ready;
	logic [KIND_W-1:0] kind         = KIND_QUERY;
	logic [HASH_W-1:0] first_hash   = '0;
	logic [HASH_W-1:0] second_hash  = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	logic              maybe_present;
	logic              underflow;

	membership_tracker sb = new;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_go = 1'b0;
	int quiet_cycles = 0;

	slot_t slot_pool [10] = '{slot_t'(0), slot_t'(1), slot_t'(2), slot_t'(3), SLOT_LAST,
		slot_t'(SLOT_LAST - 1), slot_t'(16'h1234), slot_t'(16'h8000), HOT_A, HOT_B};

	counting_bloom_filter_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.kind         (kind),
		.first_hash   (first_hash),
		.second_hash  (second_hash),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.maybe_present(maybe_present),
		.underflow    (underflow)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver throttle; one long hold-off once requested.
	initial begin
		bit held;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !held) begin
				held = 1'b1;
				result_ready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
			end else begin
				result_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) sb.note_item(kind, first_hash, second_hash);
			if (result_valid && result_ready) sb.check_result(maybe_present, underflow);
			if ((item_valid && item_ready) || (result_valid && result_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_CYCLES) begin
				$display("counting_bloom_filter_core_test: FAIL");
				$finish;
			end
		end
	end

	function automatic logic [HASH_W-1:0] hash_for(slot_t s);
		logic [HASH_W-1:0] h;
		h = $urandom;
		h[SLOT_W-1:0] = s;
		return h;
	endfunction

	function automatic slot_t pick_slot();
		return slot_pool[$urandom_range(9)];
	endfunction

	function automatic logic [KIND_W-1:0] pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 40) return KIND_MARK;
		if (r < 70) return KIND_UNMARK;
		if (r < 95) return KIND_QUERY;
		return KIND_SPARE;
	endfunction

	task automatic send_item(input logic [KIND_W-1:0] k, input logic [HASH_W-1:0] h1,
			input logic [HASH_W-1:0] h2);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid  <= 1'b1;
		kind        <= k;
		first_hash  <= h1;
		second_hash <= h2;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	task automatic run_directed();
		logic [HASH_W-1:0] shared_a;
		logic [HASH_W-1:0] shared_b;
		shared_a = hash_for(slot_t'(5));
		shared_b = hash_for(slot_t'(5));
		send_item(KIND_QUERY, '0, '1);
		send_item(KIND_UNMARK, '0, '1);      // both empty: underflow
		send_item(KIND_SPARE, '1, '1);
		send_item(KIND_MARK, shared_a, shared_b);   // shared slot counted once
		send_item(KIND_QUERY, shared_b, shared_a);
		send_item(KIND_UNMARK, shared_a, shared_b);
		send_item(KIND_UNMARK, shared_b, shared_a);
		send_item(KIND_MARK, '0, '1);
		send_item(KIND_QUERY, '0, '1);
		send_item(KIND_QUERY, '0, hash_for(slot_t'(1)));
		// first slot drains, second is empty: underflow, first still updated
		send_item(KIND_UNMARK, hash_for(slot_t'(0)), hash_for(slot_t'(1)));
		send_item(KIND_QUERY, '0, '1);
		send_item(KIND_MARK, '1, '0);
		send_item(KIND_MARK, '1, '1);
		send_item(KIND_UNMARK, '1, '0);
		send_item(KIND_QUERY, '1, '1);
		send_item(KIND_SPARE, '0, '0);
	endtask

	task automatic run_random(input int n_items, input bit fill_hot);
		int sent;
		int len;
		slot_t a;
		slot_t b;
		sent = 0;
		// drive the hot pair toward saturation; two runs push it past 255
		if (fill_hot) begin
			repeat (FILL_RUN) begin
				send_item(KIND_MARK, hash_for(HOT_A), hash_for(HOT_B));
				sent++;
			end
			repeat (3) send_item(KIND_UNMARK, hash_for(HOT_B), hash_for(HOT_A));
			send_item(KIND_QUERY, hash_for(HOT_A), hash_for(HOT_B));
		end
		while (sent < n_items) begin
			if ($urandom_range(9) == 0) begin
				send_item(KIND_W'($urandom_range(3)), $urandom, $urandom);
				sent++;
			end else begin
				a = pick_slot();
				b = ($urandom_range(4) == 0) ? a : pick_slot();
				len = $urandom_range(6, 1);
				repeat (len) begin
					if ($urandom_range(1)) send_item(pick_kind(), hash_for(a), hash_for(b));
					else send_item(pick_kind(), hash_for(b), hash_for(a));
					sent++;
				end
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 18;
		recv_idle_pct = 84;
		run_directed();
		run_random(250, 1'b1);

		send_idle_pct = 84;
		recv_idle_pct = 18;
		run_random(250, 1'b1);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_go = 1'b1;
		run_random(250, 1'b0);

		item_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("counting_bloom_filter_core_test: PASS");
		else
			$display("counting_bloom_filter_core_test: FAIL");
		$finish;
	end

endmodule
